// ===== src/distance_vector_table_update_top_defines.svh =====
// Assertion macros for the distance vector table update block.
// Included by the top level; expects clk and arst_n in scope.
`ifndef DISTANCE_VECTOR_TABLE_UPDATE_TOP_DEFINES_SVH
`define DISTANCE_VECTOR_TABLE_UPDATE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define DVT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define DVT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define DVT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define DVT_ASSERT(lbl, prop, msg)
`define DVT_ASSERT_IMP(lbl, ante, cons, msg)
`define DVT_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== src/dvt_pkg.sv =====
// Package for the distance vector table update block.
// Payload structs, table size, cost constants and codes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dvt_pkg;

	localparam int NODES = 5;
	localparam int IDX_W = 3;
	localparam int COST_W = 16;
	localparam int EXP_W = 8;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 8;

	localparam logic [COST_W-1:0] COST_INF = 16'hffff;
	localparam logic [EXP_W-1:0] RESET_EXPIRE = 8'd3;
	localparam logic [IDX_W-1:0] RESET_SELF = 3'd0;
	localparam logic [IDX_W-1:0] LAST_NODE = IDX_W'(NODES - 1);

	localparam logic [2:0] FUNC_VECTOR = 3'd0;
	localparam logic [2:0] FUNC_TICK = 3'd1;
	localparam logic [2:0] FUNC_SET = 3'd2;
	localparam logic [2:0] FUNC_DISABLE = 3'd3;
	localparam logic [2:0] FUNC_READ = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_SELF_NODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXPIRE_LIMIT = 1'd1;

	typedef struct packed {
		logic [2:0] func;
		logic [IDX_W-1:0] node_index;
		logic [IDX_W-1:0] dest_index;
		logic [COST_W-1:0] cost_value;
		logic last_entry;
	} req_t;

	typedef struct packed {
		logic [COST_W-1:0] entry_cost;
		logic [IDX_W-1:0] entry_next_hop;
		logic table_changed;
	} rsp_t;

endpackage

`default_nettype wire

// ===== src/distance_vector_table_update_top.sv =====
// Distance vector table update: routing table, vector buffer and sequencer.
// Depends on dvt_pkg and distance_vector_table_update_top_defines.svh.
// Sequence: vector entries and reads go to the report step; set/disable pass the set step, tick
//   walks every entry, last vector entry runs back, relax (one table entry per cycle) and self.
// Report waits while a result is stalled; req_stall is high until the result is loaded.
// Reset: costs infinity, next hop = own index, expiry 3, self_node 0, expire_limit 3.
`timescale 1ns / 1ps
`default_nettype none
`include "distance_vector_table_update_top_defines.svh"

module distance_vector_table_update_top
	import dvt_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic req_stall,
	input  wire req_t req,
	output logic rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t rsp,
	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_BACK = 3'd1;
	localparam logic [2:0] ST_RELAX = 3'd2;
	localparam logic [2:0] ST_SELF = 3'd3;
	localparam logic [2:0] ST_TICK = 3'd4;
	localparam logic [2:0] ST_SET = 3'd5;
	localparam logic [2:0] ST_REPORT = 3'd6;

	logic [2:0] state_q;
	logic [IDX_W-1:0] self_q;
	logic [EXP_W-1:0] limit_q;
	logic [COST_W-1:0] route_cost_q [NODES];
	logic [IDX_W-1:0] next_hop_q [NODES];
	logic [EXP_W-1:0] expire_q [NODES];
	logic [COST_W-1:0] vbuf_q [NODES];

	logic [IDX_W-1:0] node_q;
	logic [IDX_W-1:0] dest_q;
	logic [COST_W-1:0] cost_q;
	logic [COST_W-1:0] link_q;
	logic [IDX_W-1:0] k_q;
	logic ch_q;

	logic accept;
	logic [IDX_W-1:0] rd_idx;
	logic rd_ok;
	logic [COST_W-1:0] cost_rd;
	logic [IDX_W-1:0] nh_rd;
	logic [EXP_W-1:0] exp_rd;
	logic [EXP_W-1:0] exp_dec;
	logic [IDX_W-1:0] buf_idx;
	logic [COST_W-1:0] buf_rd;
	logic [COST_W-1:0] cand;
	logic self_ok;

	function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
		input logic [COST_W-1:0] b);
		logic [COST_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (a == COST_INF || b == COST_INF || s >= {1'b0, COST_INF})
			return COST_INF;
		return s[COST_W-1:0];
	endfunction

	assign req_stall = (state_q != ST_IDLE);
	assign accept = req_valid && !req_stall;
	assign cfg_ready = 1'b1;
	assign self_ok = (self_q < IDX_W'(NODES));

	always_comb begin
		case (state_q)
			ST_BACK, ST_SET: rd_idx = node_q;
			ST_RELAX, ST_TICK: rd_idx = k_q;
			default: rd_idx = dest_q;
		endcase
	end

	assign rd_ok = (rd_idx < IDX_W'(NODES));
	assign cost_rd = rd_ok ? route_cost_q[rd_idx] : COST_INF;
	assign nh_rd = rd_ok ? next_hop_q[rd_idx] : '0;
	assign exp_rd = rd_ok ? expire_q[rd_idx] : '0;
	assign exp_dec = (exp_rd != '0) ? exp_rd - EXP_W'(1) : '0;

	assign buf_idx = (state_q == ST_BACK) ? self_q : k_q;
	assign buf_rd = (buf_idx < IDX_W'(NODES)) ? vbuf_q[buf_idx] : '0;
	assign cand = sat_add(link_q, buf_rd);

	always_ff @(posedge clk) begin
		if (accept && req.func == FUNC_VECTOR && req.dest_index < IDX_W'(NODES))
			vbuf_q[req.dest_index] <= req.cost_value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			self_q <= RESET_SELF;
			limit_q <= RESET_EXPIRE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SELF_NODE: self_q <= cfg_data[IDX_W-1:0];
				REG_EXPIRE_LIMIT: limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			node_q <= req.node_index;
			dest_q <= req.dest_index;
			cost_q <= (req.func == FUNC_DISABLE) ? COST_INF : req.cost_value;
		end
		if (state_q == ST_BACK)
			link_q <= (self_ok && cost_rd > buf_rd) ? buf_rd : cost_rd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q <= '0;
			ch_q <= 1'b0;
			rsp_valid <= 1'b0;
			rsp <= '0;
			for (int i = 0; i < NODES; i++) begin
				route_cost_q[i] <= COST_INF;
				next_hop_q[i] <= IDX_W'(i);
				expire_q[i] <= RESET_EXPIRE;
			end
		end else begin
			if (rsp_valid && !rsp_stall && state_q != ST_REPORT)
				rsp_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						ch_q <= 1'b0;
						k_q <= '0;
						case (req.func)
							FUNC_VECTOR: begin
								if (req.last_entry && req.node_index < IDX_W'(NODES))
									state_q <= ST_BACK;
								else
									state_q <= ST_REPORT;
							end
							FUNC_TICK: state_q <= ST_TICK;
							FUNC_SET, FUNC_DISABLE: state_q <= ST_SET;
							default: state_q <= ST_REPORT;
						endcase
					end
				end
				ST_BACK: begin
					expire_q[rd_idx] <= limit_q;
					if (self_ok && cost_rd > buf_rd) begin
						route_cost_q[rd_idx] <= buf_rd;
						ch_q <= 1'b1;
					end
					state_q <= ST_RELAX;
				end
				ST_RELAX: begin
					if (k_q != self_q && cand < cost_rd) begin
						route_cost_q[k_q] <= cand;
						next_hop_q[k_q] <= node_q;
						ch_q <= 1'b1;
					end
					k_q <= k_q + IDX_W'(1);
					if (k_q == LAST_NODE)
						state_q <= ST_SELF;
				end
				ST_SELF: begin
					if (self_ok && route_cost_q[self_q] != '0) begin
						route_cost_q[self_q] <= '0;
						ch_q <= 1'b1;
					end
					state_q <= ST_REPORT;
				end
				ST_TICK: begin
					if (k_q == self_q) begin
						expire_q[k_q] <= '0;
					end else begin
						expire_q[k_q] <= exp_dec;
						if (exp_dec == '0 && cost_rd != COST_INF) begin
							route_cost_q[k_q] <= COST_INF;
							ch_q <= 1'b1;
						end
					end
					k_q <= k_q + IDX_W'(1);
					if (k_q == LAST_NODE)
						state_q <= ST_REPORT;
				end
				ST_SET: begin
					if (rd_ok && cost_rd != COST_INF && cost_rd != cost_q) begin
						route_cost_q[rd_idx] <= cost_q;
						ch_q <= 1'b1;
					end
					state_q <= ST_REPORT;
				end
				ST_REPORT: begin
					if (!rsp_valid || !rsp_stall) begin
						rsp_valid <= 1'b1;
						rsp.entry_cost <= cost_rd;
						rsp.entry_next_hop <= nh_rd;
						rsp.table_changed <= ch_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`DVT_ASSERT_IMP(a_relax_idx, state_q == ST_RELAX || state_q == ST_TICK, k_q <= LAST_NODE, "walk index past table end")
	`DVT_ASSERT_NXT(a_last_walk, accept && req.func == FUNC_VECTOR && req.last_entry && req.node_index < IDX_W'(NODES), state_q == ST_BACK, "last vector entry did not start update")
	`DVT_ASSERT_NXT(a_self_zero, state_q == ST_SELF && self_ok, route_cost_q[$past(self_q)] == '0, "self entry not forced to zero")
	`DVT_ASSERT_IMP(a_rsp_src, $rose(rsp_valid), $past(state_q) == ST_REPORT, "result loaded outside report step")

endmodule

`default_nettype wire
